@@ rtl/spse_pkg.sv @@
// ----------------------------------------------------------------------------
// spse_pkg
// Shared constants and types of the sorted pool with successor extraction.
// ----------------------------------------------------------------------------
`default_nettype none

package spse_pkg;

  localparam int POOL_DEPTH = 64;
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int VAL_W      = 32;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_LOADED   = 3'd0,
    ST_BEAT     = 3'd1,
    ST_FALLBACK = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic                    load;
    logic                    query;
    logic                    any_gt;
    logic signed [VAL_W-1:0] key;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/spse_cell.sv @@
// ----------------------------------------------------------------------------
// spse_cell
// One slot of the sorted pool: compares its entry against the key and moves
// entries one slot up on insert or one slot down on removal.
// ----------------------------------------------------------------------------
`default_nettype none

module spse_cell (
  input  logic                             clk,
  input  spse_pkg::cell_ctrl_t             ctrl,
  input  logic                             occ,
  input  logic                             gt_left,
  input  logic signed [spse_pkg::VAL_W-1:0] val_left,
  input  logic signed [spse_pkg::VAL_W-1:0] val_right,
  output logic                             gt,
  output logic signed [spse_pkg::VAL_W-1:0] val,
  output logic signed [spse_pkg::VAL_W-1:0] pick
);
  import spse_pkg::*;

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;

  assign gt   = occ && (val_r > ctrl.key);
  assign val  = val_r;
  assign pick = (gt && !gt_left) ? val_r : '0;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.load) begin
      if (gt_left) begin
        val_nxt = val_left;
      end else if (gt || !occ) begin
        val_nxt = ctrl.key;
      end
    end else if (ctrl.query) begin
      if (!ctrl.any_gt || gt) begin
        val_nxt = val_right;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/sorted_pool_successor_extract.sv @@
// ----------------------------------------------------------------------------
// sorted_pool_successor_extract
// Sorted pool of signed words with ordered insert and successor removal.
// ----------------------------------------------------------------------------
// The block accepts one word per clock while out_stall does not hold its
// output register, and returns its result there in the next cycle; the pool
// cells all compare against the incoming value and shift their entries in
// parallel. A load inserts the value in ascending order, after any equal
// entries, or reports full and drops it. A query removes the smallest entry
// strictly greater than the key, or else the smallest entry, or reports empty.
`default_nettype none

module sorted_pool_successor_extract (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic signed [spse_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [spse_pkg::VAL_W-1:0] out_picked,
  output logic [2:0]                        out_status
);
  import spse_pkg::*;

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_picked_r;
  status_t                 out_status_r;
  logic signed [VAL_W-1:0] picked_nxt;
  status_t                 status_nxt;

  logic                    accept;
  logic                    full;
  logic                    empty;
  cell_ctrl_t              ctrl;

  logic [POOL_DEPTH-1:0]   gt_vec;
  logic [POOL_DEPTH-1:0]   occ_vec;
  logic signed [VAL_W-1:0] cell_val  [POOL_DEPTH];
  logic signed [VAL_W-1:0] cell_pick [POOL_DEPTH];
  logic signed [VAL_W-1:0] pick_or;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(POOL_DEPTH));
  assign empty    = (count_r == '0);

  assign ctrl.load   = accept && (in_action == ACT_LOAD) && !full;
  assign ctrl.query  = accept && (in_action == ACT_QUERY) && !empty;
  assign ctrl.any_gt = |gt_vec;
  assign ctrl.key    = in_value;

  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
    assign occ_vec[i] = (CNT_W'(i) < count_r);
    spse_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ_vec[i]),
      .gt_left   ((i == 0) ? 1'b0 : gt_vec[(i == 0) ? 0 : i - 1]),
      .val_left  (cell_val[(i == 0) ? 0 : i - 1]),
      .val_right (cell_val[(i == POOL_DEPTH - 1) ? i : i + 1]),
      .gt        (gt_vec[i]),
      .val       (cell_val[i]),
      .pick      (cell_pick[i])
    );
  end

  always_comb begin
    pick_or = '0;
    for (int j = 0; j < POOL_DEPTH; j++) begin
      pick_or = pick_or | cell_pick[j];
    end
  end

  always_comb begin
    count_nxt  = count_r;
    picked_nxt = '0;
    status_nxt = ST_LOADED;
    if (in_action == ACT_LOAD) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        count_nxt = count_r - 1'b1;
        if (ctrl.any_gt) begin
          status_nxt = ST_BEAT;
          picked_nxt = pick_or;
        end else begin
          status_nxt = ST_FALLBACK;
          picked_nxt = cell_val[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_picked_r <= picked_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_picked = out_picked_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

@@ rtl/spse_checker.sv @@
// ----------------------------------------------------------------------------
// spse_checker
// Port-level checks of the sorted pool block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spse_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_action,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [spse_pkg::VAL_W-1:0] out_picked,
  input logic [2:0]                        out_status
);
  import spse_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_picked) && $stable(out_status))
    else $error("Stalled output word changed.");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("Accepted word produced no result.");

  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled while the output register was free.");

  a_load_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action == ACT_LOAD)
      |=> (out_status == ST_LOADED) || (out_status == ST_FULL))
    else $error("Load returned a query status.");

  a_zero_pick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_LOADED) || (out_status == ST_EMPTY)
      || (out_status == ST_FULL)) |-> (out_picked == '0))
    else $error("Nonzero picked value without a removal.");

endmodule

bind sorted_pool_successor_extract spse_checker u_spse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_action  (in_action),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_picked (out_picked),
  .out_status (out_status)
);

`default_nettype wire
